### design/dbflt_pkg.sv
`default_nettype none
package dbflt_pkg;

    localparam int NumBuckets = 128;
    localparam int IdxW       = 7;
    localparam int DaySeconds = 86400;
    localparam int TzW        = 17;

    // day length split as 2^7 * 675 for the day start remainder
    localparam int DayLowBits    = 7;
    localparam int DayOdd        = DaySeconds >> DayLowBits;
    localparam int DayRecipShift = 36;
    localparam logic [26:0] DayRecip =
        27'(((64'd1 << DayRecipShift) + 64'(DayOdd) - 64'd1) / 64'(DayOdd));

    // seconds per bucket and its reciprocal for the bucket index
    localparam int BucketSpan     = DaySeconds / NumBuckets;
    localparam int SpanRecipShift = 27;
    localparam logic [17:0] SpanRecip =
        18'(((64'd1 << SpanRecipShift) + 64'(BucketSpan) - 64'd1) / 64'(BucketSpan));

    // bucket tag codes
    localparam logic [7:0] EpochLast = 8'hFE;
    localparam logic [7:0] TagEmpty  = 8'hFF;

    typedef struct packed {
        logic [31:0] time_stamp;
        logic [31:0] order_key;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic        recentred;
        logic [6:0]  bucket_index;
        logic [31:0] window_start;
        logic [31:0] bucket_first_time;
        logic [31:0] bucket_last_time;
        logic [31:0] bucket_first_key;
        logic [31:0] bucket_last_key;
        logic        mark_moved;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic            accepted;
        logic            recentred;
        logic [IdxW-1:0] idx;
        logic [31:0]     window_start;
        logic [31:0]     time_stamp;
        logic [31:0]     order_key;
    } t_work;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUO,
        S_BASE,
        S_WIN,
        S_IDX,
        S_SEND
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CLR,
        B_READ,
        B_OUT
    } t_back_state;

endpackage
`default_nettype wire

### design/dbflt_front.sv
`default_nettype none
module dbflt_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic signed [16:0]     i_tz,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire dbflt_pkg::t_in_item    i_item,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output dbflt_pkg::t_work            o_work
);
    import dbflt_pkg::*;

    t_front_state r_state, n_state;
    logic [31:0]  r_wbeg;
    logic         r_wset;
    logic [31:0]  r_ts, r_key;
    logic         r_rec;
    // s = ts - tz kept as s[32:7], s[6:0] and its sign
    logic [25:0]  r_shi;
    logic [6:0]   r_slo;
    logic         r_neg;
    logic [16:0]  r_q;
    logic [16:0]  r_rem;
    logic [IdxW-1:0] r_idx;

    logic         rec_c;
    logic         ts_nz_c;
    logic [33:0]  s_c;
    logic [52:0]  qprod;
    logic [26:0]  qm_c;
    logic [26:0]  rem_c;
    logic [31:0]  b_c;
    logic [31:0]  off_c;
    logic [34:0]  prod;
    logic [IdxW:0] qb;
    logic [IdxW-1:0] idx_c;

    assign ts_nz_c = i_item.time_stamp != '0;
    assign rec_c = !r_wset || i_item.time_stamp < r_wbeg
                   || {1'b0, i_item.time_stamp} >= ({1'b0, r_wbeg} + 33'(DaySeconds));
    assign s_c   = {2'b00, i_item.time_stamp} - {{17{i_tz[16]}}, i_tz};

    // (s >> 7) / 675 by reciprocal, remainder rebuilt to s mod 86400
    assign qprod = 53'(r_shi) * 53'(DayRecip);
    assign qm_c  = 27'(r_q) * 27'(DayOdd);
    assign rem_c = {1'b0, r_shi} - qm_c;

    // day start is ts minus the remainder, clipped at zero
    always_comb begin
        if (r_neg || 32'(r_rem) > r_ts) b_c = '0;
        else b_c = r_ts - 32'(r_rem);
    end

    // offset is below one day, so offset / 675 fits the reciprocal
    assign off_c = r_ts - r_wbeg;
    assign prod  = 35'(off_c[16:0]) * 35'(SpanRecip);
    always_comb begin
        qb = prod[SpanRecipShift+IdxW:SpanRecipShift];
        idx_c = (qb > (IdxW+1)'(NumBuckets - 1)) ? IdxW'(NumBuckets - 1) : qb[IdxW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) n_state = (rec_c && ts_nz_c) ? S_QUO : S_IDX;
            end
            S_QUO: n_state = S_BASE;
            S_BASE: n_state = S_WIN;
            S_WIN: n_state = S_IDX;
            S_IDX: n_state = S_SEND;
            S_SEND: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wbeg <= '0;
            r_wset <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_ts  <= i_item.time_stamp;
                    r_key <= i_item.order_key;
                    r_rec <= rec_c && ts_nz_c;
                    r_shi <= s_c[32:7];
                    r_slo <= s_c[6:0];
                    r_neg <= s_c[33];
                end
                S_QUO: r_q <= qprod[DayRecipShift+16:DayRecipShift];
                S_BASE: r_rem <= {rem_c[9:0], r_slo};
                S_WIN: begin
                    r_wbeg <= b_c;
                    r_wset <= 1'b1;
                end
                S_IDX: r_idx <= idx_c;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_valid = (r_state == S_SEND);
        o_work.accepted     = r_ts != 0;
        o_work.recentred    = r_rec;
        o_work.idx          = (r_ts != 0) ? r_idx : '0;
        o_work.window_start = r_wbeg;
        o_work.time_stamp   = r_ts;
        o_work.order_key    = r_key;
    end
endmodule
`default_nettype wire

### design/dbflt_fifo.sv
`default_nettype none
module dbflt_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire dbflt_pkg::t_work  i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output dbflt_pkg::t_work       o_data
);
    import dbflt_pkg::*;

    t_work      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && !o_stall;
    assign rd = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end
endmodule
`default_nettype wire

### design/dbflt_back.sv
`default_nettype none
module dbflt_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire dbflt_pkg::t_work    i_work,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output dbflt_pkg::t_out_item     o_item
);
    import dbflt_pkg::*;

    // bucket store: epoch tag per entry, tags swept when the epoch wraps
    logic [127:0] r_mem [NumBuckets];
    logic [7:0]   r_tag [NumBuckets];
    logic [7:0]   r_epoch;
    logic [127:0] r_rd;
    logic [7:0]   r_rdtag;
    t_back_state  r_state, n_state;
    t_work        r_w;
    logic [IdxW-1:0] r_mslot;
    logic         r_mpres;
    t_out_item    r_out;
    logic [IdxW-1:0] r_clr;

    logic [31:0] et, lt, ek, lk;
    logic [31:0] net, nlt, nek, nlk;
    logic        wrap_c;

    assign wrap_c = i_work.recentred && (r_epoch == EpochLast);

    always_comb begin
        // a recentred item always lands in an empty bucket
        if (r_rdtag == r_epoch && !r_w.recentred) {et, lt, ek, lk} = r_rd;
        else {et, lt, ek, lk} = '0;
        {net, nlt, nek, nlk} = {et, lt, ek, lk};
        if (et == 0) begin
            {net, nlt, nek, nlk} = {r_w.time_stamp, r_w.time_stamp,
                                    r_w.order_key, r_w.order_key};
        end else if (r_w.time_stamp < et || (r_w.time_stamp == et && r_w.order_key <= ek)) begin
            net = r_w.time_stamp;
            nek = r_w.order_key;
        end else if (r_w.time_stamp > lt || (r_w.time_stamp == lt && r_w.order_key > lk)) begin
            nlt = r_w.time_stamp;
            nlk = r_w.order_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= B_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        case (r_state)
            B_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) n_state = wrap_c ? B_CLR : B_READ;
            end
            B_CLR: if (r_clr == IdxW'(NumBuckets - 1)) n_state = B_READ;
            B_READ: n_state = B_OUT;
            B_OUT: if (!i_stall) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        // memory read and write
        if (r_state == B_IDLE && i_valid) begin
            r_rd    <= r_mem[i_work.idx];
            r_rdtag <= r_tag[i_work.idx];
        end
        if (r_state == B_READ && r_w.accepted) begin
            r_mem[r_w.idx] <= {net, nlt, nek, nlk};
            r_tag[r_w.idx] <= r_epoch;
        end else if (r_state == B_CLR) begin
            r_tag[r_clr] <= TagEmpty;
        end
        if (!i_rst_n) begin
            // first window move after reset wraps the epoch and sweeps the tags
            r_epoch <= EpochLast;
            r_mpres <= 1'b0;
            r_mslot <= '0;
            r_clr   <= '0;
        end else begin
            if (r_state == B_CLR) r_clr <= r_clr + IdxW'(1);
            if (r_state == B_IDLE && i_valid) begin
                r_w <= i_work;
                if (i_work.recentred) begin
                    r_epoch <= (r_epoch == EpochLast) ? 8'd0 : r_epoch + 8'd1;
                    r_mpres <= 1'b0;
                end
            end
            if (r_state == B_READ) begin
                r_out.accepted  <= r_w.accepted;
                r_out.recentred <= r_w.recentred;
                r_out.bucket_index <= r_w.idx;
                r_out.window_start <= r_w.window_start;
                r_out.bucket_first_time <= r_w.accepted ? net : '0;
                r_out.bucket_last_time  <= r_w.accepted ? nlt : '0;
                r_out.bucket_first_key  <= r_w.accepted ? nek : '0;
                r_out.bucket_last_key   <= r_w.accepted ? nlk : '0;
                r_out.mark_moved <= r_w.accepted && !(r_mpres && r_mslot == r_w.idx);
                if (r_w.accepted) begin
                    r_mslot <= r_w.idx;
                    r_mpres <= 1'b1;
                end
            end
        end
    end

    assign o_valid = (r_state == B_OUT);
    assign o_item  = r_out;
endmodule
`default_nettype wire

### design/day_bucket_first_last_tracker.sv
// an item that moves the window takes the extra front states S_QUO, S_BASE and S_WIN
// the front part takes a new item only in its idle state, once the last one is passed on
// a window move that wraps the 8-bit bucket epoch adds a sweep of all 128 bucket tags in the back
// part: the first move after reset, then every 255th
// reset: synchronous active low; no window, tz_offset zero, mark cleared
`default_nettype none
module day_bucket_first_last_tracker (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [16:0]          i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire dbflt_pkg::t_in_item  i_item,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output dbflt_pkg::t_out_item      o_item
);
    import dbflt_pkg::*;

    logic signed [16:0] r_tz;
    t_work  f_work, q_work;
    logic   f_valid, f_stall, q_valid, q_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tz <= '0;
        else if (i_cfg_we) r_tz <= i_cfg_data;
    end

    dbflt_front u_front (
        .i_clk, .i_rst_n, .i_tz(r_tz),
        .i_valid, .o_stall, .i_item,
        .o_valid(f_valid), .i_stall(f_stall), .o_work(f_work)
    );

    dbflt_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_stall(f_stall), .i_data(f_work),
        .o_valid(q_valid), .i_stall(q_stall), .o_data(q_work)
    );

    dbflt_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_stall(q_stall), .i_work(q_work),
        .o_valid, .i_stall, .o_item
    );
endmodule
`default_nettype wire
